[hw/rtl/afd_pkg.sv]
package afd_pkg;

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_SUMHI = 3'd4,
    PH_SUMLO = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam logic REASON_CHECKSUM = 1'b0;
  localparam logic REASON_TIMEOUT  = 1'b1;

  localparam logic CFG_OWN_ADDRESS = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  localparam logic [7:0] OWN_ADDRESS_RESET = 8'd0;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd130;

endpackage

[hw/rtl/addressed_frame_deframer.sv]
// A result item appears on the master side in the cycle after its input item is taken.
// Throughput: one input item per cycle; the output register lets a new item in while a
// result waits, as long as the master side takes it in the same cycle.
// Reset (rst, synchronous, active high): back to waiting for an address byte, own_address
// 0, max_payload 130, no result pending.
module addressed_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] command
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [15:8] message_type,
                                      // [23:16] payload_length, [24] reject_reason, rest 0
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import afd_pkg::*;

  logic [7:0]  own_address;
  logic [7:0]  max_payload;

  phase_t      phase, phase_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_high_byte, sum_high_byte_next;

  logic        out_valid, out_valid_next;
  kind_t       out_kind;
  logic [7:0]  out_data;
  logic [7:0]  out_type;
  logic [7:0]  out_length;
  logic        out_reason;

  logic        accept;
  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_data;
  logic        emit_reason;
  logic [7:0]  rx_byte;
  logic [15:0] check;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;
  assign check         = {sum_high_byte, rx_byte};

  always_comb begin
    phase_next         = phase;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    sum_high_byte_next = sum_high_byte;
    emit               = 1'b0;
    emit_kind          = KIND_DATA;
    emit_data          = 8'd0;
    emit_reason        = REASON_CHECKSUM;

    if (s_axis_tuser == CMD_TIMEOUT) begin
      phase_next = PH_ADDR;
      // only a frame past its header reports the timeout
      if (phase == PH_DATA || phase == PH_SUMHI || phase == PH_SUMLO) begin
        emit        = 1'b1;
        emit_kind   = KIND_REJECT;
        emit_reason = REASON_TIMEOUT;
      end
    end else begin
      case (phase)
        PH_TYPE: begin
          frame_type_next  = rx_byte;
          running_sum_next = running_sum + {8'd0, rx_byte};
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte > max_payload) begin
            phase_next = PH_ADDR;
          end else begin
            frame_length_next = rx_byte;
            bytes_left_next   = rx_byte;
            running_sum_next  = running_sum + {8'd0, rx_byte};
            phase_next        = (rx_byte != 8'd0) ? PH_DATA : PH_SUMHI;
          end
        end
        PH_DATA: begin
          running_sum_next = running_sum + {8'd0, rx_byte};
          bytes_left_next  = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_SUMHI;
          end
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_data = rx_byte;
        end
        PH_SUMHI: begin
          sum_high_byte_next = rx_byte;
          phase_next         = PH_SUMLO;
        end
        PH_SUMLO: begin
          phase_next = PH_ADDR;
          emit       = 1'b1;
          emit_kind  = (check == running_sum) ? KIND_ACCEPT : KIND_REJECT;
        end
        default: begin
          // address phase, and unused codes
          phase_next = PH_ADDR;
          if (rx_byte == own_address) begin
            running_sum_next = {8'd0, rx_byte};
            phase_next       = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end
    if (accept && emit) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS: own_address <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload <= cfg_data;
        default:         own_address <= own_address;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ADDR;
      frame_type    <= 8'd0;
      frame_length  <= 8'd0;
      bytes_left    <= 8'd0;
      running_sum   <= 16'd0;
      sum_high_byte <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        phase         <= phase_next;
        frame_type    <= frame_type_next;
        frame_length  <= frame_length_next;
        bytes_left    <= bytes_left_next;
        running_sum   <= running_sum_next;
        sum_high_byte <= sum_high_byte_next;
      end
    end
  end

  // result register; type and length are the frame's values before this item
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind   <= emit_kind;
      out_data   <= emit_data;
      out_type   <= frame_type;
      out_length <= frame_length;
      out_reason <= emit_reason;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {7'd0, out_reason, out_length, out_type, out_data};

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import afd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    kind_t      kind;
    logic       reason;
    logic [7:0] plen;
    logic [7:0] mtype;
    logic [7:0] data;
  } frame_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_OWN_ADDRESS;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = CMD_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  addressed_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // deframer mirror
  phase_t      rx_phase;
  logic [7:0]  cur_type, cur_len, bytes_left, sum_hi;
  logic [15:0] sum_acc;
  logic [7:0]  my_addr, len_limit;

  frame_event_t expected_events[$];
  int  useful_items = 0;
  int  errors = 0;
  int  cycles = 0;
  int  hold_cycles = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser !== want.kind ||
            m_axis_tdata !== {7'd0, want.reason, want.plen, want.mtype, want.data}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind %0d/%0d data %h/%h type %h/%h len %h/%h reason %0d/%0d pad %h",
                     want.kind, m_axis_tuser, want.data, m_axis_tdata[7:0],
                     want.mtype, m_axis_tdata[15:8], want.plen, m_axis_tdata[23:16],
                     want.reason, m_axis_tdata[24], m_axis_tdata[31:25]);
        end
      end
    end
  end

  function automatic void deframe_reset();
    rx_phase   = PH_ADDR;
    cur_type   = 8'h00;
    cur_len    = 8'h00;
    bytes_left = 8'h00;
    sum_acc    = 16'h0000;
    sum_hi     = 8'h00;
    my_addr    = OWN_ADDRESS_RESET;
    len_limit  = MAX_PAYLOAD_RESET;
  endfunction

  function automatic void deframe_step(input logic cmd, input logic [7:0] b);
    frame_event_t ev;
    bit emit;
    bit ignored;
    ev = '0;
    emit = 1'b0;
    ignored = 1'b0;
    if (cmd == CMD_TIMEOUT) begin
      ignored = (rx_phase == PH_ADDR);
      if (rx_phase inside {PH_DATA, PH_SUMHI, PH_SUMLO}) begin
        emit = 1'b1;
        ev.kind = KIND_REJECT;
        ev.reason = REASON_TIMEOUT;
      end
      rx_phase = PH_ADDR;
    end else begin
      case (rx_phase)
        PH_TYPE: begin
          cur_type = b;
          sum_acc = sum_acc + 16'(b);
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          if (b > len_limit) begin
            rx_phase = PH_ADDR;
          end else begin
            cur_len = b;
            bytes_left = b;
            sum_acc = sum_acc + 16'(b);
            rx_phase = (b != 8'h00) ? PH_DATA : PH_SUMHI;
          end
        end
        PH_DATA: begin
          sum_acc = sum_acc + 16'(b);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) rx_phase = PH_SUMHI;
          emit = 1'b1;
          ev.kind = KIND_DATA;
          ev.data = b;
        end
        PH_SUMHI: begin
          sum_hi = b;
          rx_phase = PH_SUMLO;
        end
        PH_SUMLO: begin
          rx_phase = PH_ADDR;
          emit = 1'b1;
          ev.kind = ({sum_hi, b} == sum_acc) ? KIND_ACCEPT : KIND_REJECT;
          ev.reason = REASON_CHECKSUM;
        end
        default: begin
          rx_phase = PH_ADDR;
          if (b == my_addr) begin
            sum_acc = {8'h00, b};
            rx_phase = PH_TYPE;
          end else begin
            ignored = 1'b1;
          end
        end
      endcase
    end
    if (!ignored) useful_items++;
    if (emit) begin
      ev.mtype = cur_type;
      ev.plen = cur_len;
      expected_events.push_back(ev);
    end
  endfunction

  // valid is only lowered ahead of a gap, so it never gets two updates in one step
  task automatic send_item(input logic cmd, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deframe_step(cmd, b);
  endtask

  // cut >= 0 replaces the item at that position with a timeout and ends the frame
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] typ,
                            input logic [7:0] len, input int fill,
                            input bit bad_sum, input int cut);
    logic [7:0]  frame_bytes[$];
    logic [15:0] sum;
    logic [7:0]  p;
    frame_bytes = {addr, typ, len};
    sum = 16'(addr) + 16'(typ) + 16'(len);
    for (int i = 0; i < len; i++) begin
      p = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_bytes.push_back(p);
      sum = sum + 16'(p);
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
    foreach (frame_bytes[i]) begin
      if (i == cut) begin
        send_item(CMD_TIMEOUT, 8'($urandom));
        return;
      end
      send_item(CMD_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // cfg_we stays high across both writes and drops once
  task automatic write_config(input logic [7:0] addr, input logic [7:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    my_addr = addr;
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data <= limit;
    @(posedge clk);
    len_limit = limit;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int goal;
    int r;
    logic [7:0] len, cap;
    goal = useful_items + count;
    while (useful_items < goal) begin
      r = $urandom_range(0, 99);
      cap = (len_limit < 8'd12) ? len_limit : 8'd12;
      if (r < 65) begin
        // realign first so most frames get through
        if (rx_phase != PH_ADDR) send_item(CMD_TIMEOUT, 8'($urandom));
        len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, len_limit))
                                           : 8'($urandom_range(0, cap));
        send_frame(my_addr, 8'($urandom), len,
                   ($urandom_range(0, 9) == 0) ? 255 : -1,
                   $urandom_range(0, 6) == 0,
                   ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len + 4)) : -1);
      end else if (r < 75 && len_limit != 8'hFF) begin
        if (rx_phase != PH_ADDR) send_item(CMD_TIMEOUT, 8'($urandom));
        send_item(CMD_BYTE, my_addr);
        send_item(CMD_BYTE, 8'($urandom));
        send_item(CMD_BYTE, 8'($urandom_range(len_limit + 1, 255)));
      end else if (r < 85) begin
        send_frame(my_addr ^ 8'($urandom_range(1, 255)), 8'($urandom),
                   8'($urandom_range(0, cap)), -1, 1'b0, -1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(($urandom_range(0, 3) == 0) ? CMD_TIMEOUT : CMD_BYTE,
                    ($urandom_range(0, 3) == 0) ? my_addr : 8'($urandom));
      end
    end
  endtask

  task automatic test_reset_frames();
    send_frame(8'h00, 8'hFF, 8'd1, 255, 1'b0, -1);
    send_frame(8'h00, 8'h00, 8'd0, -1, 1'b1, -1);
  endtask

  task automatic test_reject_paths();
    send_item(CMD_TIMEOUT, 8'hFF);
    // timeout while the length byte is due: silent
    send_frame(8'h00, 8'h11, 8'd3, -1, 1'b0, 2);
    // timeout inside the payload: rejected
    send_frame(8'h00, 8'h22, 8'd1, -1, 1'b0, 3);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_config(8'hFF, 8'h00);
    // oversized length drops the frame; next byte is a fresh address
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h5A);
    send_item(CMD_BYTE, 8'h01);
    send_frame(8'hFF, 8'h80, 8'd0, -1, 1'b0, -1);
  endtask

  task automatic test_random_traffic();
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      case (k)
        0: write_config(8'h00, 8'hFF);
        1: write_config(8'hFF, 8'h00);
        2: write_config(8'($urandom), 8'd3);
        default: write_config(8'($urandom), 8'($urandom_range(1, 255)));
      endcase
      // all-ones longest frame brings the 16-bit sum to FFFF without wrapping
      if (k == 0) send_frame(my_addr, 8'hFF, 8'hFF, 255, 1'b0, -1);
      random_traffic(85);
    end
  endtask

  task automatic test_output_hold();
    wait_idle();
    write_config(8'h5A, 8'd200);
    hold_cycles <= HOLD_LEN;
    send_frame(8'h5A, 8'h77, 8'd40, -1, 1'b0, -1);
    wait_idle();
  endtask

  task automatic test_steady_stream();
    wait_idle();
    idle_on = 1'b0;
    write_config(8'h81, 8'd20);
    random_traffic(100);
  endtask

  initial begin
    deframe_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_frames();
    test_reject_paths();
    test_config_extremes();
    test_output_hold();
    test_random_traffic();
    test_steady_stream();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
